// ===== rtl/brs_pkg.sv =====
// ----------------------------------------------------------------------------
// brs_pkg - shared types and constants for the branch relocation scanner
// Opcode values, branch kind codes, operand lengths and the result request
// passed from the front end through the queue to the output stage.
// ----------------------------------------------------------------------------
package brs_pkg;

  // Branch kind codes as reported on branch_kind
  typedef enum logic [2:0] {
    KIND_CALL32 = 3'd0,
    KIND_JMP32  = 3'd1,
    KIND_JMP8   = 3'd2,
    KIND_JCC32  = 3'd3,
    KIND_JCC8   = 3'd4
  } kind_t;

  // Opcode bytes
  localparam logic [7:0] OP_CALL32    = 8'hE8;
  localparam logic [7:0] OP_JMP32     = 8'hE9;
  localparam logic [7:0] OP_JMP8      = 8'hEB;
  localparam logic [7:0] OP_ESCAPE    = 8'h0F;
  localparam logic [7:0] OP_JCC32_LO  = 8'h80;
  localparam logic [7:0] OP_JCC32_HI  = 8'h8F;
  localparam logic [7:0] OP_JCC8_LO   = 8'h70;
  localparam logic [7:0] OP_JCC8_HI   = 8'h7F;

  // Whole instruction lengths and operand bytes skipped after a match
  localparam logic [31:0] LEN_REL32  = 32'd5;
  localparam logic [31:0] LEN_REL8   = 32'd2;
  localparam logic [31:0] LEN_MIN    = 32'd5;
  localparam logic [2:0]  SKIP_REL32 = 3'd4;
  localparam logic [2:0]  SKIP_REL8  = 3'd1;

  localparam logic [31:0] POS_MAX = 32'hFFFF_FFFF;

  // Default depth of the result queue (power of two, at least 2)
  localparam int QUEUE_DEPTH = 2;

  // One result request
  typedef struct packed {
    logic [31:0] offset;
    kind_t       kind;
  } result_t;

endpackage

// ===== rtl/brs_front.sv =====
// ----------------------------------------------------------------------------
// brs_front - byte decoder and scan state
// Accepts one code byte per cycle while the queue has room, tracks offset,
// operand skip and pending 0F escape, and pushes a request per branch found.
// ----------------------------------------------------------------------------
module brs_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_wr_en,
  input  logic [31:0]        cfg_wr_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [7:0]         code_byte,
  input  logic               buffer_start,
  input  logic               push_ready,
  output logic               push_valid,
  output brs_pkg::result_t   push_data
);

  logic [31:0] code_length;
  logic [31:0] byte_position;
  logic [31:0] byte_position_next;
  logic [2:0]  skip_remaining;
  logic [2:0]  skip_remaining_next;
  logic        escape_pending;
  logic        escape_pending_next;

  logic        accept;
  logic [31:0] pos_cur;
  logic [2:0]  skip_cur;
  logic        esc_cur;
  logic [32:0] rem;
  logic        past_end;
  logic        fit_rel32;
  logic        fit_rel8;
  logic        is_jcc32_tail;
  logic        is_jcc8;
  logic        hit;

  // Byte is taken whenever the queue has room
  assign in_ready = push_ready;
  assign accept   = in_valid & push_ready;

  // A new buffer restarts offset, skip and escape
  assign pos_cur  = buffer_start ? '0 : byte_position;
  assign skip_cur = buffer_start ? '0 : skip_remaining;
  assign esc_cur  = buffer_start ? 1'b0 : escape_pending;

  // Bytes left from this offset to the end of the buffer
  assign rem       = {1'b0, code_length} - {1'b0, pos_cur};
  assign past_end  = rem[32] | (rem == '0);
  assign fit_rel32 = rem[31:0] >= brs_pkg::LEN_REL32;
  assign fit_rel8  = rem[31:0] >= brs_pkg::LEN_REL8;

  // jcc rel32 after 0F at pos-1 needs pos-1+6 <= len, i.e. rem >= 5
  assign is_jcc32_tail = esc_cur && (pos_cur != '0) &&
                         (code_byte >= brs_pkg::OP_JCC32_LO) &&
                         (code_byte <= brs_pkg::OP_JCC32_HI) && fit_rel32;
  assign is_jcc8       = (code_byte >= brs_pkg::OP_JCC8_LO) &&
                         (code_byte <= brs_pkg::OP_JCC8_HI) && fit_rel8;

  // Saturating offset
  assign byte_position_next = (pos_cur == brs_pkg::POS_MAX) ? pos_cur : pos_cur + 32'd1;

  // Decode
  always_comb begin
    skip_remaining_next = 3'd0;
    escape_pending_next = 1'b0;
    hit                 = 1'b0;
    push_data.offset    = pos_cur;
    push_data.kind      = brs_pkg::KIND_CALL32;
    priority if (code_length < brs_pkg::LEN_MIN || past_end) begin
      skip_remaining_next = 3'd0;
    end else if (skip_cur != 3'd0) begin
      skip_remaining_next = skip_cur - 3'd1;
    end else if (is_jcc32_tail) begin
      hit                 = 1'b1;
      push_data.offset    = pos_cur - 32'd1;
      push_data.kind      = brs_pkg::KIND_JCC32;
      skip_remaining_next = brs_pkg::SKIP_REL32;
    end else if (code_byte == brs_pkg::OP_CALL32 && fit_rel32) begin
      hit                 = 1'b1;
      push_data.kind      = brs_pkg::KIND_CALL32;
      skip_remaining_next = brs_pkg::SKIP_REL32;
    end else if (code_byte == brs_pkg::OP_JMP32 && fit_rel32) begin
      hit                 = 1'b1;
      push_data.kind      = brs_pkg::KIND_JMP32;
      skip_remaining_next = brs_pkg::SKIP_REL32;
    end else if (code_byte == brs_pkg::OP_JMP8 && fit_rel8) begin
      hit                 = 1'b1;
      push_data.kind      = brs_pkg::KIND_JMP8;
      skip_remaining_next = brs_pkg::SKIP_REL8;
    end else if (code_byte == brs_pkg::OP_ESCAPE) begin
      escape_pending_next = 1'b1;
    end else if (is_jcc8) begin
      hit                 = 1'b1;
      push_data.kind      = brs_pkg::KIND_JCC8;
      skip_remaining_next = brs_pkg::SKIP_REL8;
    end else begin
      skip_remaining_next = 3'd0;
    end
  end

  assign push_valid = accept & hit;

  // Length register
  always_ff @(posedge clk) begin
    if (rst) begin
      code_length <= '0;
    end else if (cfg_wr_en) begin
      code_length <= cfg_wr_data;
    end
  end

  // Scan state
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position  <= '0;
      skip_remaining <= '0;
      escape_pending <= 1'b0;
    end else if (accept) begin
      byte_position  <= byte_position_next;
      skip_remaining <= skip_remaining_next;
      escape_pending <= escape_pending_next;
    end
  end

endmodule

// ===== rtl/brs_queue.sv =====
// ----------------------------------------------------------------------------
// brs_queue - result request queue
// Small FIFO between the decoder and the output stage so either side can
// stall without holding up the other.
// ----------------------------------------------------------------------------
module brs_queue #(
  parameter int DEPTH = brs_pkg::QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push_valid,
  output logic             push_ready,
  input  brs_pkg::result_t push_data,
  output logic             pop_valid,
  input  logic             pop_ready,
  output brs_pkg::result_t pop_data
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  brs_pkg::result_t entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign push_ready = (count != CNT_W'(DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_data   = entries[rd_ptr];
  assign do_push    = push_valid & push_ready;
  assign do_pop     = pop_valid & pop_ready;

  // Storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + PTR_W'(1);
      end
      unique case ({do_push, do_pop})
        2'b10:   count <= count + CNT_W'(1);
        2'b01:   count <= count - CNT_W'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

// ===== rtl/brs_back.sv =====
// ----------------------------------------------------------------------------
// brs_back - output stage
// Holds one result request in a register and presents it on the output
// channel until the receiver takes it.
// ----------------------------------------------------------------------------
module brs_back (
  input  logic             clk,
  input  logic             rst,
  input  logic             pop_valid,
  output logic             pop_ready,
  input  brs_pkg::result_t pop_data,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [31:0]      branch_offset,
  output logic [2:0]       branch_kind
);

  logic             held;
  brs_pkg::result_t data;

  // Load when empty or the held request is leaving
  assign pop_ready = ~held | out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else if (pop_ready) begin
      held <= pop_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (pop_ready && pop_valid) begin
      data <= pop_data;
    end
  end

  assign out_valid     = held;
  assign branch_offset = data.offset;
  assign branch_kind   = data.kind;

endmodule

// ===== rtl/x86_branch_reloc_scanner.sv =====
// ----------------------------------------------------------------------------
// x86_branch_reloc_scanner - x86 relative branch scanner
// Scans a code buffer byte by byte and reports each relative branch found.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready): one code byte per request, with
//   buffer_start set on the first byte of each buffer. A byte is taken
//   every cycle while the result queue has room.
//   Output channel (out_valid/out_ready): one request per branch found,
//   carrying the opcode offset and the branch kind.
//   cfg_wr_en/cfg_wr_data set the buffer length; write it only while idle.
//   Throughput is one byte per cycle while the queue has room; the decoder
//   settles each byte in the cycle it is taken. A result reaches the output
//   through the queue write, then the output register.
//   When the receiver stalls, results collect in the QUEUE_DEPTH-entry queue
//   plus the output register; in_ready drops only once the queue is full.
//   Reset clears the length, offset, skip and escape state and empties the
//   queue and output register; no clearing pass is needed.
// ----------------------------------------------------------------------------
module x86_branch_reloc_scanner #(
  parameter int QUEUE_DEPTH = brs_pkg::QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic [31:0] cfg_wr_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  code_byte,
  input  logic        buffer_start,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] branch_offset,
  output logic [2:0]  branch_kind
);

  logic             push_valid;
  logic             push_ready;
  brs_pkg::result_t push_data;
  logic             pop_valid;
  logic             pop_ready;
  brs_pkg::result_t pop_data;

  // Decoder
  brs_front u_front (
    .clk          (clk),
    .rst          (rst),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .code_byte    (code_byte),
    .buffer_start (buffer_start),
    .push_ready   (push_ready),
    .push_valid   (push_valid),
    .push_data    (push_data)
  );

  // Result queue
  brs_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  // Output register
  brs_back u_back (
    .clk           (clk),
    .rst           (rst),
    .pop_valid     (pop_valid),
    .pop_ready     (pop_ready),
    .pop_data      (pop_data),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .branch_offset (branch_offset),
    .branch_kind   (branch_kind)
  );

endmodule

// ===== rtl/brs_checker.sv =====
// ----------------------------------------------------------------------------
// brs_checker - port-level checks for the branch scanner
// Watches the top-level ports and flags broken output holding, reset
// behaviour, back-pressure ordering and undefined branch kinds.
// ----------------------------------------------------------------------------
module brs_checker (
  input logic        clk,
  input logic        rst,
  input logic        cfg_wr_en,
  input logic [31:0] cfg_wr_data,
  input logic        in_valid,
  input logic        in_ready,
  input logic [7:0]  code_byte,
  input logic        buffer_start,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] branch_offset,
  input logic [2:0]  branch_kind
);

  // A stalled result request holds its payload
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(branch_offset) &&
      $stable(branch_kind))
    else $error("stalled result changed");

  // Reset empties the output and reopens the input
  assert property (@(posedge clk) rst |=> !out_valid && in_ready)
    else $error("reset left output busy or input blocked");

  // Input only blocks when results are piled up behind a stalled output
  assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> out_valid)
    else $error("input blocked with no result waiting");

  // Reported kinds stay within the defined codes
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> branch_kind <= brs_pkg::KIND_JCC8)
    else $error("undefined branch kind");

endmodule

bind x86_branch_reloc_scanner brs_checker u_checker (.*);

// ===== bench/x86_branch_reloc_scanner_test.sv =====
// ----------------------------------------------------------------------------
// x86_branch_reloc_scanner_test - testbench for the x86 relative branch scanner
// Streams code buffers into the scanner byte by byte and checks every branch
// request that comes out against an in-bench decoder. Directed buffers cover
// each branch kind, short buffers and bytes past the end. Random buffers are
// mostly well-formed instruction streams with random operands. Both channels
// idle at random in the first two of three phases.
// ----------------------------------------------------------------------------
module x86_branch_reloc_scanner_test;

  localparam int CYCLE_LIMIT = 200000;
  localparam int SETTLE_CYCLES = 4;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_wr_en = 1'b0;
  logic [31:0] cfg_wr_data = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  code_byte = '0;
  logic        buffer_start = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [31:0] branch_offset;
  logic [2:0]  branch_kind;

  // Decoder state mirrored in the bench
  logic [31:0] scan_length = '0;
  logic [31:0] scan_pos = '0;
  logic [2:0]  scan_skip = '0;
  logic        scan_escape = 1'b0;

  brs_pkg::result_t pending_branches[$];
  int      mismatch_count = 0;
  int      cycle_count = 0;
  int      sender_idle_pct = 0;
  int      receiver_idle_pct = 0;

  x86_branch_reloc_scanner dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .code_byte    (code_byte),
    .buffer_start (buffer_start),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .branch_offset(branch_offset),
    .branch_kind  (branch_kind)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Receiver back-pressure
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= receiver_idle_pct);
  end

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch at cycle %0d: %s got %0h expected %0h", cycle_count, what, got, want);
    mismatch_count++;
  endtask

  // Result checker: each request against the oldest expected branch
  always @(posedge clk) begin
    brs_pkg::result_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_branches.size() == 0) begin
        report_mismatch("unexpected branch at offset", branch_offset, '0);
      end else begin
        want = pending_branches.pop_front();
        if (branch_offset !== want.offset)
          report_mismatch("branch_offset", branch_offset, want.offset);
        if (branch_kind !== want.kind)
          report_mismatch("branch_kind", 32'(branch_kind), 32'(want.kind));
      end
    end
  end

  // True when n bytes from 'at' lie inside the buffer
  function automatic bit branch_fits(input logic [31:0] at, input logic [31:0] n);
    return ({1'b0, at} + {1'b0, n}) <= {1'b0, scan_length};
  endfunction

  function automatic void note_branch(input logic [31:0] at, input brs_pkg::kind_t kind);
    brs_pkg::result_t r;
    r.offset = at;
    r.kind = kind;
    pending_branches.push_back(r);
  endfunction

  // Bench decoder: advance the scan by one accepted byte
  function automatic void predict_branch(input logic [7:0] b, input logic first);
    logic [31:0] at;
    logic        was_escape;
    if (first) begin
      scan_pos = '0;
      scan_skip = '0;
      scan_escape = 1'b0;
    end
    at = scan_pos;
    if (scan_pos != brs_pkg::POS_MAX) scan_pos = scan_pos + 32'd1;

    if (scan_length < brs_pkg::LEN_MIN || at >= scan_length) begin
      scan_skip = '0;
      scan_escape = 1'b0;
      return;
    end
    if (scan_skip != 3'd0) begin
      scan_skip = scan_skip - 3'd1;
      return;
    end

    was_escape = scan_escape;
    scan_escape = 1'b0;
    // 0F resolved by the byte after it; the 0F plus a rel32 is six bytes
    if (was_escape && at != 32'd0 && b >= brs_pkg::OP_JCC32_LO &&
        b <= brs_pkg::OP_JCC32_HI &&
        branch_fits(at - 32'd1, brs_pkg::LEN_REL32 + 32'd1)) begin
      scan_skip = brs_pkg::SKIP_REL32;
      note_branch(at - 32'd1, brs_pkg::KIND_JCC32);
      return;
    end

    if (b == brs_pkg::OP_CALL32 && branch_fits(at, brs_pkg::LEN_REL32)) begin
      scan_skip = brs_pkg::SKIP_REL32;
      note_branch(at, brs_pkg::KIND_CALL32);
    end else if (b == brs_pkg::OP_JMP32 && branch_fits(at, brs_pkg::LEN_REL32)) begin
      scan_skip = brs_pkg::SKIP_REL32;
      note_branch(at, brs_pkg::KIND_JMP32);
    end else if (b == brs_pkg::OP_JMP8 && branch_fits(at, brs_pkg::LEN_REL8)) begin
      scan_skip = brs_pkg::SKIP_REL8;
      note_branch(at, brs_pkg::KIND_JMP8);
    end else if (b == brs_pkg::OP_ESCAPE) begin
      scan_escape = 1'b1;
    end else if (b >= brs_pkg::OP_JCC8_LO && b <= brs_pkg::OP_JCC8_HI &&
                 branch_fits(at, brs_pkg::LEN_REL8)) begin
      scan_skip = brs_pkg::SKIP_REL8;
      note_branch(at, brs_pkg::KIND_JCC8);
    end
  endfunction

  // Send one byte request, with a random gap first
  task automatic send_byte(input logic [7:0] b, input logic first);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    code_byte <= b;
    buffer_start <= first;
    do @(posedge clk); while (!in_ready);
    predict_branch(b, first);
  endtask

  // Hold off the sender until every expected branch has come out
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_branches.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_length(input logic [31:0] len);
    wait_idle();
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= len;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    scan_length = len;
  endtask

  task automatic send_bytes(input logic [7:0] bytes_q[$]);
    foreach (bytes_q[i]) send_byte(bytes_q[i], i == 0);
  endtask

  function automatic logic [31:0] pick_length();
    int r;
    r = $urandom_range(19);
    if (r == 0) return 32'($urandom_range(4));
    if (r == 1) return brs_pkg::POS_MAX;
    if (r == 2) return 32'($urandom);
    return 32'($urandom_range(5, 32));
  endfunction

  // Append one instruction (or a noise byte) with random operands
  function automatic void append_instruction(ref logic [7:0] q[$]);
    int r;
    r = $urandom_range(9);
    case (r)
      0: q.push_back(brs_pkg::OP_CALL32);
      1: q.push_back(brs_pkg::OP_JMP32);
      2: q.push_back(brs_pkg::OP_JMP8);
      3: begin
        q.push_back(brs_pkg::OP_ESCAPE);
        q.push_back(brs_pkg::OP_JCC32_LO | 8'($urandom_range(15)));
      end
      4: q.push_back(brs_pkg::OP_JCC8_LO | 8'($urandom_range(15)));
      5: begin
        q.push_back(brs_pkg::OP_ESCAPE);
        q.push_back(8'($urandom));
      end
      default: q.push_back(8'($urandom));
    endcase
    if (r <= 1 || r == 3) repeat (4) q.push_back(8'($urandom));
    else if (r == 2 || r == 4) q.push_back(8'($urandom));
  endfunction

  // Lengths below five give nothing, however good the opcode
  task automatic test_short_buffers();
    set_length(32'd0);
    send_bytes('{brs_pkg::OP_CALL32});
    set_length(32'd4);
    send_bytes('{brs_pkg::OP_JCC8_LO});
  endtask

  // Each branch kind, operand skipping, the fit limit and bytes past the end
  task automatic test_branch_kinds();
    // call32 then jmp8 ending right at the limit, then a jcc8 past the end
    set_length(32'd7);
    send_bytes('{brs_pkg::OP_CALL32, brs_pkg::OP_JMP32, brs_pkg::OP_CALL32,
                 brs_pkg::OP_JMP8, brs_pkg::OP_ESCAPE, brs_pkg::OP_JMP8,
                 brs_pkg::OP_JCC8_HI, brs_pkg::OP_JCC8_LO});
    // jcc32 that fits, then one that does not and falls back to a plain byte
    set_length(32'd8);
    send_bytes('{brs_pkg::OP_ESCAPE, brs_pkg::OP_JCC32_HI, brs_pkg::OP_CALL32,
                 brs_pkg::OP_ESCAPE, brs_pkg::OP_JMP8, 8'hFF, brs_pkg::OP_ESCAPE,
                 8'h85});
    // jcc8, then a 0F followed by jmp32 decoded on its own
    set_length(brs_pkg::POS_MAX);
    send_bytes('{brs_pkg::OP_JCC8_HI, brs_pkg::OP_ESCAPE, brs_pkg::OP_ESCAPE,
                 brs_pkg::OP_JMP32, 8'h00, 8'h80, brs_pkg::OP_CALL32, 8'h7F});
  endtask

  task automatic test_random_buffers(input int item_goal);
    int          sent;
    int          n;
    int          split_at;
    bit          fresh;
    logic [7:0]  bytes_q[$];
    sent = 0;
    while (sent < item_goal) begin
      if (sent == 0 || $urandom_range(2) == 0) set_length(pick_length());
      n = (scan_length <= 32'd40) ? int'(scan_length) + $urandom_range(1, 3)
                                  : $urandom_range(8, 40);
      bytes_q = {};
      while (bytes_q.size() < n) append_instruction(bytes_q);
      split_at = ($urandom_range(7) == 0) ? $urandom_range(n - 1) : 0;
      // now and then carry on from the previous buffer without a restart
      fresh = ($urandom_range(9) != 0);
      for (int i = 0; i < n; i++) begin
        if (i == split_at && i != 0) set_length(pick_length());
        send_byte(bytes_q[i], fresh && i == 0);
      end
      sent += n;
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    sender_idle_pct = 29;
    receiver_idle_pct = 67;
    test_short_buffers();
    test_branch_kinds();
    test_random_buffers(150);

    sender_idle_pct = 67;
    receiver_idle_pct = 29;
    test_random_buffers(150);

    sender_idle_pct = 0;
    receiver_idle_pct = 0;
    test_random_buffers(150);

    wait_idle();
    repeat (8) @(posedge clk);
    if (pending_branches.size() != 0)
      report_mismatch("branches never reported", 32'(pending_branches.size()), '0);
    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
